/* sv/stwd_pkg.sv */
package stwd_pkg;

    localparam int CW   = 16;
    localparam int FRAC = CW - 2;
    localparam int PW   = 2 * CW;
    localparam int RW   = 2 * CW + 1;
    localparam int DW   = 2 * CW - 1;
    localparam int QW   = CW - 1;
    localparam int SQ_ST = (CW + 1) / 2;
    localparam int DV_ST = CW / 2;
    localparam int NL    = 3 + SQ_ST + 1 + DV_ST + 1;
    localparam int LAT   = 9 + 2 * NL;

    typedef logic signed [CW-1:0]  t_comp;
    typedef logic signed [CW+1:0]  t_wide;
    typedef logic signed [PW-1:0]  t_prod;

    localparam t_comp ONE = t_comp'(1 << FRAC);
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (FRAC - 1);

    localparam logic [1:0] CFG_AXIS_X = 2'd0;
    localparam logic [1:0] CFG_AXIS_Y = 2'd1;
    localparam logic [1:0] CFG_AXIS_Z = 2'd2;

    typedef struct packed {
        t_comp rot_x;
        t_comp rot_y;
        t_comp rot_z;
        t_comp rot_w;
    } t_in;

    typedef struct packed {
        t_comp swing_x;
        t_comp swing_y;
        t_comp swing_z;
        t_comp swing_w;
        t_comp twist_x;
        t_comp twist_y;
        t_comp twist_z;
        t_comp twist_w;
        logic  degenerate;
    } t_out;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] root;
    } t_sq;

    function automatic t_comp sat_comp(input logic [CW-1:0] v);
        t_comp s;
        s = signed'(v);
        if (s > ONE) begin
            return ONE;
        end else if (s < -ONE) begin
            return -ONE;
        end
        return s;
    endfunction

    // round to Q1.F, half away from zero
    function automatic t_wide rnd_q(input t_prod v);
        logic [PW-1:0] mg;
        logic [PW-1:0] r;
        mg = v[PW-1] ? (~v + 1'b1) : v;
        r  = (mg + HALF_LSB) >> FRAC;
        return v[PW-1] ? -t_wide'(r) : t_wide'(r);
    endfunction

    function automatic t_sq sq_step(input t_sq x, input int it);
        logic [RW-1:0] b;
        t_sq y;
        b = RW'(1) << (2 * (CW - 1 - it));
        if (x.rem >= x.root + b) begin
            y.rem  = x.rem - (x.root + b);
            y.root = (x.root >> 1) + b;
        end else begin
            y.rem  = x.rem;
            y.root = x.root >> 1;
        end
        return y;
    endfunction

endpackage

/* sv/stwd_norm4.sv */
module stwd_norm4 import stwd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_wide i_v [4],
    output logic  o_valid,
    output t_comp o_q [4],
    output logic  o_zero
);

    logic            r_a_vld;
    logic [QW-1:0]   r_a_m   [4];
    logic [3:0]      r_a_neg;
    logic            r_b_vld;
    logic [2*QW-1:0] r_b_sq  [4];
    logic [QW-1:0]   r_b_m   [4];
    logic [3:0]      r_b_neg;
    logic            r_c_vld;
    logic [PW-1:0]   r_c_sum;
    logic [QW-1:0]   r_c_m   [4];
    logic [3:0]      r_c_neg;
    logic            r_c_zero;

    logic            r_s_vld  [SQ_ST];
    t_sq             r_s_sq   [SQ_ST];
    t_sq             n_s_sq   [SQ_ST];
    logic [QW-1:0]   r_s_m    [SQ_ST][4];
    logic [3:0]      r_s_neg  [SQ_ST];
    logic            r_s_zero [SQ_ST];

    logic            r_d_vld;
    logic [DW-1:0]   r_d_num [4];
    logic [CW-1:0]   r_d_s;
    logic [3:0]      r_d_neg;
    logic            r_d_zero;

    logic            r_v_vld  [DV_ST];
    logic [DW-1:0]   r_v_rem  [DV_ST][4];
    logic [QW-1:0]   r_v_q    [DV_ST][4];
    logic [DW-1:0]   n_v_rem  [DV_ST][4];
    logic [QW-1:0]   n_v_q    [DV_ST][4];
    logic [CW-1:0]   r_v_s    [DV_ST];
    logic [3:0]      r_v_neg  [DV_ST];
    logic            r_v_zero [DV_ST];

    logic            r_e_vld;
    t_comp           r_e_q [4];
    logic            r_e_zero;

    logic [CW:0]     a_mag [4];
    logic [CW+1:0]   a_tmp;
    logic [CW:0]     a_top;
    logic [1:0]      a_sh;

    always_comb begin
        a_top = '0;
        for (int i = 0; i < 4; i++) begin
            a_tmp    = i_v[i][CW+1] ? (~i_v[i] + 1'b1) : i_v[i];
            a_mag[i] = a_tmp[CW:0];
            if (a_mag[i] > a_top) begin
                a_top = a_mag[i];
            end
        end
        if (a_top[CW]) begin
            a_sh = 2'd2;
        end else if (a_top[CW-1]) begin
            a_sh = 2'd1;
        end else begin
            a_sh = 2'd0;
        end
    end

    always_comb begin
        t_sq cur;
        for (int j = 0; j < SQ_ST; j++) begin
            cur = (j == 0) ? t_sq'{rem: RW'(r_c_sum), root: '0} : r_s_sq[(j == 0) ? 0 : j - 1];
            for (int k = 0; k < 2; k++) begin
                if (2 * j + k < CW) begin
                    cur = sq_step(cur, 2 * j + k);
                end
            end
            n_s_sq[j] = cur;
        end
    end

    always_comb begin
        logic [DW-1:0] rem;
        logic [QW-1:0] q;
        logic [DW-1:0] dsh;
        int b;
        for (int j = 0; j < DV_ST; j++) begin
            for (int i = 0; i < 4; i++) begin
                rem = (j == 0) ? r_d_num[i] : r_v_rem[(j == 0) ? 0 : j - 1][i];
                q   = (j == 0) ? '0 : r_v_q[(j == 0) ? 0 : j - 1][i];
                for (int k = 0; k < 2; k++) begin
                    b = CW - 2 - (2 * j + k);
                    if (b >= 0) begin
                        dsh = DW'((j == 0) ? r_d_s : r_v_s[(j == 0) ? 0 : j - 1]) << b;
                        if (rem >= dsh) begin
                            rem = rem - dsh;
                            q   = q | (QW'(1) << b);
                        end
                    end
                end
                n_v_rem[j][i] = rem;
                n_v_q[j][i]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            for (int j = 0; j < SQ_ST; j++) begin
                r_s_vld[j] <= 1'b0;
            end
            for (int j = 0; j < DV_ST; j++) begin
                r_v_vld[j] <= 1'b0;
            end
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_s_vld[0] <= r_c_vld;
            for (int j = 1; j < SQ_ST; j++) begin
                r_s_vld[j] <= r_s_vld[j-1];
            end
            r_d_vld <= r_s_vld[SQ_ST-1];
            r_v_vld[0] <= r_d_vld;
            for (int j = 1; j < DV_ST; j++) begin
                r_v_vld[j] <= r_v_vld[j-1];
            end
            r_e_vld <= r_v_vld[DV_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_a_m[i]   <= QW'(a_mag[i] >> a_sh);
            r_a_neg[i] <= i_v[i][CW+1];
            r_b_sq[i]  <= r_a_m[i] * r_a_m[i];
            r_b_m[i]   <= r_a_m[i];
            r_c_m[i]   <= r_b_m[i];
        end
        r_b_neg  <= r_a_neg;
        r_c_sum  <= PW'(r_b_sq[0]) + PW'(r_b_sq[1]) + PW'(r_b_sq[2]) + PW'(r_b_sq[3]);
        r_c_neg  <= r_b_neg;
        r_c_zero <= (r_b_sq[0] == '0) && (r_b_sq[1] == '0) && (r_b_sq[2] == '0)
                    && (r_b_sq[3] == '0);

        for (int j = 0; j < SQ_ST; j++) begin
            r_s_sq[j] <= n_s_sq[j];
        end
        r_s_m[0]    <= r_c_m;
        r_s_neg[0]  <= r_c_neg;
        r_s_zero[0] <= r_c_zero;
        for (int j = 1; j < SQ_ST; j++) begin
            r_s_m[j]    <= r_s_m[j-1];
            r_s_neg[j]  <= r_s_neg[j-1];
            r_s_zero[j] <= r_s_zero[j-1];
        end

        r_d_s    <= r_s_sq[SQ_ST-1].root[CW-1:0];
        for (int i = 0; i < 4; i++) begin
            r_d_num[i] <= (DW'(r_s_m[SQ_ST-1][i]) << FRAC)
                          + DW'(r_s_sq[SQ_ST-1].root[CW-1:1]);
        end
        r_d_neg  <= r_s_neg[SQ_ST-1];
        r_d_zero <= r_s_zero[SQ_ST-1];

        for (int j = 0; j < DV_ST; j++) begin
            r_v_rem[j] <= n_v_rem[j];
            r_v_q[j]   <= n_v_q[j];
        end
        r_v_s[0]    <= r_d_s;
        r_v_neg[0]  <= r_d_neg;
        r_v_zero[0] <= r_d_zero;
        for (int j = 1; j < DV_ST; j++) begin
            r_v_s[j]    <= r_v_s[j-1];
            r_v_neg[j]  <= r_v_neg[j-1];
            r_v_zero[j] <= r_v_zero[j-1];
        end

        for (int i = 0; i < 4; i++) begin
            if (r_v_q[DV_ST-1][i] > QW'(ONE)) begin
                r_e_q[i] <= r_v_neg[DV_ST-1][i] ? -ONE : ONE;
            end else begin
                r_e_q[i] <= r_v_neg[DV_ST-1][i] ? -t_comp'(r_v_q[DV_ST-1][i])
                                                : t_comp'(r_v_q[DV_ST-1][i]);
            end
        end
        r_e_zero <= r_v_zero[DV_ST-1];
    end

    assign o_valid = r_e_vld;
    assign o_q     = r_e_q;
    assign o_zero  = r_e_zero;

endmodule

/* sv/swing_twist_decompose.sv */
// Swing-twist split of a unit quaternion about a programmable axis, fully
// pipelined: one item may start in every cycle and its result strobes out
// once it has passed both normalisers, each a 21-stage chain of square
// root and four-lane division, two bits a stage.
// busy is never raised and results cannot be held off. Write the axis only
// while no item is in flight.
module swing_twist_decompose import stwd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_in        i_item,
    output logic       o_valid,
    output t_out       o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  t_comp      i_cfg_data
);

    t_comp r_ax [3];
    logic  axis_zero;

    logic  r0_vld, r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    t_comp r0_r [4];
    t_comp r1_r [4];
    t_prod r1_p [3];
    t_comp r2_r [4];
    t_wide r2_d;
    t_comp r3_r [4];
    t_wide r3_t [4];

    logic  n1_vld, n1_zero;
    t_comp n1_q [4];
    t_comp r_dl1 [NL][4];

    t_comp r4_r [4];
    t_comp r4_tw [4];
    t_prod r4_p [3];
    logic  r4_zt;
    t_comp r5_r [4];
    t_comp r5_tw [4];
    logic  r5_zt;
    t_prod r6_p [16];
    t_comp r6_tw [4];
    logic  r6_zt;
    t_wide r7_sv [4];
    t_comp r7_tw [4];
    logic  r7_zt;

    logic  n2_vld, n2_zero;
    t_comp n2_q [4];
    t_comp r_dl2_tw [NL][4];
    logic  r_dl2_zt [NL];

    logic  r_out_vld;
    t_out  r_out;
    t_out  n_out;

    logic  neg_w;
    t_comp rn [4];
    t_prod tdot;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign axis_zero   = (r_ax[0] == '0) && (r_ax[1] == '0) && (r_ax[2] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax[0] <= '0;
            r_ax[1] <= ONE;
            r_ax[2] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_AXIS_X: r_ax[0] <= sat_comp(i_cfg_data);
                CFG_AXIS_Y: r_ax[1] <= sat_comp(i_cfg_data);
                CFG_AXIS_Z: r_ax[2] <= sat_comp(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        neg_w = r0_r[3] < 0;
        for (int i = 0; i < 4; i++) begin
            rn[i] = neg_w ? -r0_r[i] : r0_r[i];
        end
        tdot = r4_p[0] + r4_p[1] + r4_p[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r0_vld    <= i_start && !o_busy;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= n1_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r_out_vld <= n2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_r[0] <= sat_comp(i_item.rot_x);
        r0_r[1] <= sat_comp(i_item.rot_y);
        r0_r[2] <= sat_comp(i_item.rot_z);
        r0_r[3] <= sat_comp(i_item.rot_w);

        r1_r <= rn;
        for (int i = 0; i < 3; i++) begin
            r1_p[i] <= rn[i] * r_ax[i];
        end

        r2_r <= r1_r;
        r2_d <= rnd_q(r1_p[0] + r1_p[1] + r1_p[2]);

        r3_r <= r2_r;
        for (int i = 0; i < 3; i++) begin
            r3_t[i] <= rnd_q(t_prod'(r_ax[i] * r2_d));
        end
        r3_t[3] <= t_wide'(r2_r[3]);

        r_dl1[0] <= r3_r;
        for (int j = 1; j < NL; j++) begin
            r_dl1[j] <= r_dl1[j-1];
        end

        r4_r  <= r_dl1[NL-1];
        r4_tw <= n1_q;
        r4_zt <= n1_zero;
        for (int i = 0; i < 3; i++) begin
            r4_p[i] <= n1_q[i] * r_ax[i];
        end

        r5_r  <= r4_r;
        r5_zt <= r4_zt;
        for (int i = 0; i < 4; i++) begin
            r5_tw[i] <= tdot[PW-1] ? -r4_tw[i] : r4_tw[i];
        end

        // rotation times conjugate of twist
        r6_p[0]  <= r5_r[3] * r5_tw[0];
        r6_p[1]  <= r5_r[0] * r5_tw[3];
        r6_p[2]  <= r5_r[1] * r5_tw[2];
        r6_p[3]  <= r5_r[2] * r5_tw[1];
        r6_p[4]  <= r5_r[3] * r5_tw[1];
        r6_p[5]  <= r5_r[1] * r5_tw[3];
        r6_p[6]  <= r5_r[2] * r5_tw[0];
        r6_p[7]  <= r5_r[0] * r5_tw[2];
        r6_p[8]  <= r5_r[3] * r5_tw[2];
        r6_p[9]  <= r5_r[2] * r5_tw[3];
        r6_p[10] <= r5_r[0] * r5_tw[1];
        r6_p[11] <= r5_r[1] * r5_tw[0];
        r6_p[12] <= r5_r[3] * r5_tw[3];
        r6_p[13] <= r5_r[0] * r5_tw[0];
        r6_p[14] <= r5_r[1] * r5_tw[1];
        r6_p[15] <= r5_r[2] * r5_tw[2];
        r6_tw <= r5_tw;
        r6_zt <= r5_zt;

        r7_sv[0] <= rnd_q(-r6_p[0] + r6_p[1] - r6_p[2] + r6_p[3]);
        r7_sv[1] <= rnd_q(-r6_p[4] + r6_p[5] - r6_p[6] + r6_p[7]);
        r7_sv[2] <= rnd_q(-r6_p[8] + r6_p[9] - r6_p[10] + r6_p[11]);
        r7_sv[3] <= rnd_q(r6_p[12] + r6_p[13] + r6_p[14] + r6_p[15]);
        r7_tw <= r6_tw;
        r7_zt <= r6_zt;

        r_dl2_tw[0] <= r7_tw;
        r_dl2_zt[0] <= r7_zt;
        for (int j = 1; j < NL; j++) begin
            r_dl2_tw[j] <= r_dl2_tw[j-1];
            r_dl2_zt[j] <= r_dl2_zt[j-1];
        end

        r_out <= n_out;
    end

    always_comb begin
        n_out = '{swing_w: ONE, twist_w: ONE, default: '0};
        n_out.degenerate = 1'b1;
        if (!axis_zero && !r_dl2_zt[NL-1]) begin
            n_out.twist_x = r_dl2_tw[NL-1][0];
            n_out.twist_y = r_dl2_tw[NL-1][1];
            n_out.twist_z = r_dl2_tw[NL-1][2];
            n_out.twist_w = r_dl2_tw[NL-1][3];
            if (!n2_zero) begin
                n_out.swing_x    = n2_q[0];
                n_out.swing_y    = n2_q[1];
                n_out.swing_z    = n2_q[2];
                n_out.swing_w    = n2_q[3];
                n_out.degenerate = 1'b0;
            end
        end
    end

    stwd_norm4 u_norm_twist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_v     (r3_t),
        .o_valid (n1_vld),
        .o_q     (n1_q),
        .o_zero  (n1_zero)
    );

    stwd_norm4 u_norm_swing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_v     (r7_sv),
        .o_valid (n2_vld),
        .o_q     (n2_q),
        .o_zero  (n2_zero)
    );

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("item result missing at fixed latency");

    a_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && axis_zero) |-> o_result.degenerate)
        else $error("zero axis without degenerate flag");

    a_twist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.twist_w <= ONE && o_result.twist_w >= -ONE
                     && o_result.swing_w <= ONE && o_result.swing_w >= -ONE))
        else $error("w component out of range");
`endif

endmodule
